// File: rtl/core/file_mode_spec_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// File mode spec parser assertion macros
// Assertion shorthands for the spec parser, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef FILE_MODE_SPEC_PARSER_UNIT_DEFINES_SVH
`define FILE_MODE_SPEC_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FMSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmsp assertion failed");
`define FMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmsp assertion failed");
`else
`define FMSP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/fmsp_pkg.sv
// ----------------------------------------------------------------------------
// File mode spec parser package
// Phase, operator, error and character codes, mode masks, state/result types.
// ----------------------------------------------------------------------------
package fmsp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_OCTAL,
        PH_CLASS,
        PH_PERM,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_SET
    } t_op;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_EMPTY     = 3'd1;
    localparam logic [2:0] ERR_NOT_OCTAL = 3'd2;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd3;
    localparam logic [2:0] ERR_NO_OP     = 3'd4;
    localparam logic [2:0] ERR_SETUID    = 3'd5;
    localparam logic [2:0] ERR_STICKY    = 3'd6;
    localparam logic [2:0] ERR_BAD_PERM  = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_SEVEN = "7";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_U     = "u";
    localparam logic [7:0] CH_G     = "g";
    localparam logic [7:0] CH_O     = "o";
    localparam logic [7:0] CH_A     = "a";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_W     = "w";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_COMMA = ",";

    localparam logic [8:0] MODE_USER  = 9'o700;
    localparam logic [8:0] MODE_GROUP = 9'o070;
    localparam logic [8:0] MODE_OTHER = 9'o007;
    localparam logic [8:0] MODE_ALL   = 9'o777;
    localparam logic [8:0] MODE_READ  = 9'o444;
    localparam logic [8:0] MODE_WRITE = 9'o222;
    localparam logic [8:0] MODE_EXEC  = 9'o111;

    typedef struct packed {
        t_phase     phase;
        logic [8:0] working_mode;
        logic [2:0] class_mask;
        t_op        clause_op;
        logic [2:0] perm_letters;
        logic [8:0] octal_value;
        logic       octal_too_large;
        logic [2:0] pending_error;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:           PH_START,
        working_mode:    9'd0,
        class_mask:      3'd0,
        clause_op:       OP_NONE,
        perm_letters:    3'd0,
        octal_value:     9'd0,
        octal_too_large: 1'b0,
        pending_error:   ERR_OK
    };

    typedef struct packed {
        logic       valid;
        logic [8:0] new_mode;
        logic [2:0] error_code;
    } t_result;

endpackage

// File: rtl/core/fmsp_step.sv
// ----------------------------------------------------------------------------
// File mode spec parser step
// Next parser state and optional result for one spec character.
// ----------------------------------------------------------------------------
module fmsp_step (
    input  fmsp_pkg::t_state  i_state,
    input  logic [7:0]        i_character,
    input  logic [8:0]        i_current_mode,
    output fmsp_pkg::t_state  o_state,
    output fmsp_pkg::t_result o_result
);
    import fmsp_pkg::*;

    function automatic t_state fail(input t_state s, input logic [2:0] code);
        t_state r;
        r = s;
        r.pending_error = code;
        r.phase         = PH_ERROR;
        return r;
    endfunction

    function automatic t_state apply_clause(input t_state s);
        t_state     r;
        logic [8:0] who;
        logic [8:0] bits;
        r    = s;
        who  = (s.class_mask[2] ? MODE_USER  : 9'd0)
             | (s.class_mask[1] ? MODE_GROUP : 9'd0)
             | (s.class_mask[0] ? MODE_OTHER : 9'd0);
        if (who == 9'd0) begin
            who = MODE_ALL;
        end
        bits = (s.perm_letters[2] ? MODE_READ  : 9'd0)
             | (s.perm_letters[1] ? MODE_WRITE : 9'd0)
             | (s.perm_letters[0] ? MODE_EXEC  : 9'd0);
        bits = bits & who;
        unique case (s.clause_op)
            OP_ADD:  r.working_mode = s.working_mode | bits;
            OP_SUB:  r.working_mode = s.working_mode & ~bits;
            default: r.working_mode = (s.working_mode & ~who) | bits;
        endcase
        r.class_mask   = 3'd0;
        r.perm_letters = 3'd0;
        r.clause_op    = OP_NONE;
        return r;
    endfunction

    function automatic t_state class_char(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        unique case (c)
            CH_U: r.class_mask = s.class_mask | 3'b100;
            CH_G: r.class_mask = s.class_mask | 3'b010;
            CH_O: r.class_mask = s.class_mask | 3'b001;
            CH_A: r.class_mask = 3'b111;
            CH_PLUS, CH_MINUS, CH_EQ: begin
                r.clause_op    = (c == CH_PLUS)  ? OP_ADD :
                                 (c == CH_MINUS) ? OP_SUB : OP_SET;
                r.perm_letters = 3'd0;
                r.phase        = PH_PERM;
            end
            default: r = fail(s, ERR_NO_OP);
        endcase
        return r;
    endfunction

    function automatic t_state octal_char(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        if (c < CH_ZERO || c > CH_SEVEN) begin
            r = fail(s, ERR_NOT_OCTAL);
        end else begin
            if (s.octal_value[8:6] != 3'd0) begin
                r.octal_too_large = 1'b1;
            end
            r.octal_value = {s.octal_value[5:0], c[2:0]};
        end
        return r;
    endfunction

    function automatic t_state perm_char(input t_state s, input logic [7:0] c);
        t_state r;
        r = s;
        unique case (c)
            CH_R: r.perm_letters = s.perm_letters | 3'b100;
            CH_W: r.perm_letters = s.perm_letters | 3'b010;
            CH_X: r.perm_letters = s.perm_letters | 3'b001;
            CH_S: r = fail(s, ERR_SETUID);
            CH_T: r = fail(s, ERR_STICKY);
            CH_COMMA: begin
                r       = apply_clause(s);
                r.phase = PH_CLASS;
            end
            default: r = fail(s, ERR_BAD_PERM);
        endcase
        return r;
    endfunction

    t_state     s_start;
    t_state     s_applied;
    logic [8:0] s_mode;
    logic [2:0] s_err;

    always_comb begin
        s_start   = i_state;
        s_applied = apply_clause(i_state);
        s_mode    = 9'd0;
        s_err     = ERR_OK;
        o_state   = i_state;
        o_result  = '0;

        if (i_character == CH_NUL) begin
            unique case (i_state.phase)
                PH_START: s_err = ERR_EMPTY;
                PH_OCTAL: begin
                    if (i_state.octal_too_large) begin
                        s_err = ERR_TOO_LARGE;
                    end else begin
                        s_mode = i_state.octal_value;
                    end
                end
                PH_CLASS: s_err = ERR_NO_OP;
                PH_PERM:  s_mode = s_applied.working_mode;
                default:  s_err = i_state.pending_error;
            endcase
            o_result.valid      = 1'b1;
            o_result.new_mode   = (s_err != ERR_OK) ? 9'd0 : s_mode;
            o_result.error_code = s_err;
            o_state             = STATE_RESET;
        end else begin
            unique case (i_state.phase)
                PH_START: begin
                    if (i_character >= CH_ZERO && i_character <= CH_NINE) begin
                        s_start.phase           = PH_OCTAL;
                        s_start.octal_value     = 9'd0;
                        s_start.octal_too_large = 1'b0;
                        o_state = octal_char(s_start, i_character);
                    end else begin
                        s_start.working_mode = i_current_mode;
                        s_start.class_mask   = 3'd0;
                        s_start.phase        = PH_CLASS;
                        o_state = class_char(s_start, i_character);
                    end
                end
                PH_OCTAL: o_state = octal_char(i_state, i_character);
                PH_CLASS: o_state = class_char(i_state, i_character);
                PH_PERM:  o_state = perm_char(i_state, i_character);
                default:  o_state = i_state;
            endcase
        end
    end

endmodule

// File: rtl/core/file_mode_spec_parser_unit.sv
// ----------------------------------------------------------------------------
// File mode spec parser unit
// Parses an octal or symbolic permission spec one character word at a time.
// A terminator word's result word is registered and shown the cycle after
// acceptance. Throughput: one character word per cycle, the parser state
// register the only loop; only a terminator word stalls, while a result word
// waits and i_ready is low. Reset: synchronous, active low; parser state
// returns to start of spec and any waiting result word is dropped.
// ----------------------------------------------------------------------------
`include "file_mode_spec_parser_unit_defines.svh"

module file_mode_spec_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_character,
    input  logic [8:0] i_current_mode,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [8:0] o_new_mode,
    output logic [2:0] o_error_code
);
    import fmsp_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_result    s_result;
    logic       r_valid;
    logic       n_valid;
    logic [8:0] r_new_mode;
    logic [2:0] r_error_code;
    logic       s_accept;

    fmsp_step u_step (
        .i_state        (r_state),
        .i_character    (i_character),
        .i_current_mode (i_current_mode),
        .o_state        (n_state),
        .o_result       (s_result)
    );

    assign o_ready  = !r_valid || i_ready || (i_character != CH_NUL);
    assign s_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (s_accept && s_result.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (s_accept) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && s_result.valid) begin
            r_new_mode   <= s_result.new_mode;
            r_error_code <= s_result.error_code;
        end
    end

    assign o_valid      = r_valid;
    assign o_new_mode   = r_new_mode;
    assign o_error_code = r_error_code;

    `FMSP_ASSERT_NEXT(a_term_gives_result, i_clk, i_rst_n, s_accept && (i_character == CH_NUL), o_valid)
    `FMSP_ASSERT_NEXT(a_term_restarts, i_clk, i_rst_n, s_accept && (i_character == CH_NUL), r_state.phase == PH_START)
    `FMSP_ASSERT_SAME(a_error_zero_mode, i_clk, i_rst_n, o_valid && (o_error_code != ERR_OK), o_new_mode == 9'd0)
    `FMSP_ASSERT_SAME(a_error_phase_code, i_clk, i_rst_n, r_state.phase == PH_ERROR, r_state.pending_error != ERR_OK)

endmodule
